// ----- src/wmfh_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wmfh_pkg;

	localparam logic [63:0] SEED_RESET = 64'h5f2a1c0d7b3e9146;
	localparam logic [63:0] GOLDEN_ADD = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MUL_FIRST  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MUL_SECOND = 64'h94d049bb133111eb;

	localparam int SHIFT_FIRST  = 30;
	localparam int SHIFT_SECOND = 27;
	localparam int SHIFT_FINAL  = 31;

	typedef enum logic [1:0] {
		KIND_WORD    = 2'd0,
		KIND_TAIL    = 2'd1,
		KIND_INT     = 2'd2,
		KIND_RESTART = 2'd3
	} kind_t;

	localparam logic [7:0] REG_SEED     = 8'd0;
	localparam logic [7:0] REG_EXPECTED = 8'd1;

	// The first tail byte ends up most significant; bytes at or beyond count are dropped.
	function automatic logic [63:0] pack_tail(input logic [63:0] word, input logic [2:0] count);
		logic [63:0] packed_v;
		logic [2:0]  pos;
		packed_v = '0;
		for (int k = 0; k < 7; k++) begin
			pos = 3'(int'(count) - 1 - k);
			if (3'(k) < count) begin
				packed_v = packed_v | (64'(word[8*k +: 8]) << {pos, 3'b000});
			end
		end
		return packed_v;
	endfunction

endpackage

`default_nettype wire

// ----- src/word_mix_fingerprint_hash_core.sv -----
// Word-mix fingerprint hash core.
// Input requests arrive on the s_ channel: s_tuser carries the item kind
// (full word, run tail, integer, restart) and s_tdata carries the data word
// and the tail byte count. Each request yields exactly one result on the m_
// channel: the new 64-bit accumulator and a flag set when it equals the
// expected fingerprint register.
// Configuration writes use cfg_valid/cfg_ready with cfg_index 0 for the seed
// and 1 for the expected fingerprint; other indexes are ignored.
// A mixing request passes these steps after acceptance: the golden-ratio add
// and first xor-shift, then two 64-bit multiplies on one shared 32x32
// multiplier, then the compare and the load of the output register. A restart
// loads the seed and goes straight to that compare and load.
// s_tready is low while a request is in progress; the next request may be
// accepted as soon as the result has moved to the output register, so the
// core never takes a new request before it is through with the last one.
// If the receiver stalls, the finished result waits in the core until the
// output register is free. Reset clears the accumulator to the seed reset
// value and leaves both channels empty.
`timescale 1ns / 1ps
`default_nettype none

module word_mix_fingerprint_hash_core
	import wmfh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // data_word [63:0], byte_count [66:64], zero fill
	input  wire logic [1:0]  s_tuser,   // kind [1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // fingerprint [63:0], matches_expected [64], zero fill
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ADD  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]  state_q;
	logic [1:0]  phase_q;
	logic        second_q;
	logic [63:0] acc_q;
	logic [63:0] seed_q;
	logic [63:0] expected_q;
	logic [63:0] opa_q;
	logic [63:0] sum_q;
	logic [63:0] mul_q;
	logic        m_valid_q;
	logic [63:0] fp_q;
	logic        match_q;

	kind_t       in_kind;
	logic [63:0] in_word;
	logic [2:0]  in_count;
	logic [63:0] mix_in;
	logic [63:0] add_v;
	logic [63:0] mul_const;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic        accept;
	logic        out_free;

	assign in_kind  = kind_t'(s_tuser);
	assign in_word  = s_tdata[63:0];
	assign in_count = s_tdata[66:64];

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'b0, match_q, fp_q};

	always_comb begin
		unique case (in_kind)
			KIND_TAIL: mix_in = acc_q ^ pack_tail(in_word, in_count);
			default:   mix_in = acc_q ^ in_word;
		endcase
	end

	assign add_v = opa_q + GOLDEN_ADD;

	// Shared 32x32 multiplier: low x low, low x high, high x low partial products.
	assign mul_const = second_q ? MUL_SECOND : MUL_FIRST;
	assign mul_a     = (phase_q == 2'd2) ? opa_q[63:32] : opa_q[31:0];
	assign mul_b     = (phase_q == 2'd1) ? mul_const[63:32] : mul_const[31:0];
	assign prod      = sum_q + {mul_q[31:0], 32'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q     <= SEED_RESET;
			expected_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_SEED) begin
				seed_q <= cfg_data;
			end else if (cfg_index == REG_EXPECTED) begin
				expected_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= 64'(mul_a) * 64'(mul_b);
		unique case (phase_q)
			2'd1:    sum_q <= mul_q;
			2'd2:    sum_q <= prod;
			default: sum_q <= sum_q;
		endcase
		if (accept) begin
			opa_q <= mix_in;
		end else if (state_q == ST_ADD) begin
			opa_q <= add_v ^ (add_v >> SHIFT_FIRST);
		end else if (state_q == ST_MUL && phase_q == 2'd3 && !second_q) begin
			opa_q <= prod ^ (prod >> SHIFT_SECOND);
		end
		if (state_q == ST_DONE && out_free) begin
			fp_q    <= acc_q;
			match_q <= (acc_q == expected_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= '0;
			second_q  <= 1'b0;
			acc_q     <= SEED_RESET;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_kind == KIND_RESTART) begin
							acc_q   <= seed_q;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_ADD;
						end
					end
				end
				ST_ADD: begin
					phase_q  <= '0;
					second_q <= 1'b0;
					state_q  <= ST_MUL;
				end
				ST_MUL: begin
					phase_q <= phase_q + 2'd1;
					if (phase_q == 2'd3) begin
						if (second_q) begin
							acc_q   <= prod ^ (prod >> SHIFT_FINAL);
							state_q <= ST_DONE;
						end else begin
							second_q <= 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("core still ready after taking a request");

	a_match_flag: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> (m_tdata[64] == (m_tdata[63:0] == expected_q)))
		else $error("match flag disagrees with fingerprint");

	a_restart_loads_seed: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == KIND_RESTART) |=> acc_q == $past(seed_q))
		else $error("restart did not load the seed");

	a_mix_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) && (phase_q == 2'd3) && second_q |=> state_q == ST_DONE)
		else $error("second multiply did not finish the mix");

	a_done_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && (!m_valid_q || m_tready) |=> m_tvalid && fp_q == acc_q)
		else $error("finished result not moved to the output register");
`endif

endmodule

`default_nettype wire

// ----- tb/word_mix_fingerprint_hash_checker.sv -----
`timescale 1ns / 1ps

module word_mix_fingerprint_hash_checker
	import wmfh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [71:0] s_tdata,   // data_word [63:0], byte_count [66:64], zero fill
	input  wire logic [1:0]  s_tuser,   // kind [1:0]
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [71:0] m_tdata,   // fingerprint [63:0], matches_expected [64], zero fill
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	output int               fail_count,
	output int               fp_pending
);

	typedef struct packed {
		logic [63:0] fp;
		logic        hit;
	} fp_result_t;

	fp_result_t  fp_due_q[$];
	logic [63:0] acc_model;
	logic [63:0] seed_copy;
	logic [63:0] target_copy;
	int          fails = 0;
	int          pending = 0;

	assign fail_count = fails;
	assign fp_pending = pending;

	function automatic logic [63:0] splitmix_fold(input logic [63:0] v);
		logic [63:0] x;
		x = v + GOLDEN_ADD;
		x = (x ^ (x >> SHIFT_FIRST)) * MUL_FIRST;
		x = (x ^ (x >> SHIFT_SECOND)) * MUL_SECOND;
		return x ^ (x >> SHIFT_FINAL);
	endfunction

	// Bytes are taken in stream order and shifted up, so the first one ends most significant.
	function automatic logic [63:0] tail_value(input logic [63:0] word, input logic [2:0] count);
		logic [63:0] packed_v;
		packed_v = '0;
		for (int k = 0; k < 7; k++) begin
			if (k < count) begin
				packed_v = {packed_v[55:0], word[8*k +: 8]};
			end
		end
		return packed_v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fp_result_t  due;
		logic [63:0] word;
		logic [2:0]  count;
		if (!arst_n) begin
			acc_model   = SEED_RESET;
			seed_copy   = SEED_RESET;
			target_copy = '0;
			fp_due_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SEED: begin
						seed_copy = cfg_data;
					end
					REG_EXPECTED: begin
						target_copy = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (fp_due_q.size() == 0) begin
					$display("%0t: result with no request pending, fingerprint %h match %b",
						$time, m_tdata[63:0], m_tdata[64]);
					fails++;
				end else begin
					due = fp_due_q.pop_front();
					if (m_tdata[63:0] !== due.fp) begin
						$display("%0t: fingerprint expected %h actual %h",
							$time, due.fp, m_tdata[63:0]);
						fails++;
					end
					if (m_tdata[64] !== due.hit) begin
						$display("%0t: match flag expected %b actual %b (fingerprint %h)",
							$time, due.hit, m_tdata[64], due.fp);
						fails++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				word  = s_tdata[63:0];
				count = s_tdata[66:64];
				case (kind_t'(s_tuser))
					KIND_WORD, KIND_INT: begin
						acc_model = splitmix_fold(acc_model ^ word);
					end
					KIND_TAIL: begin
						acc_model = splitmix_fold(acc_model ^ tail_value(word, count));
					end
					default: begin
						acc_model = seed_copy;
					end
				endcase
				due.fp  = acc_model;
				due.hit = (acc_model == target_copy);
				fp_due_q = {fp_due_q, due};
			end
			pending = fp_due_q.size();
		end
	end

endmodule

// ----- tb/word_mix_fingerprint_hash_core_test.sv -----
`timescale 1ns / 1ps

module word_mix_fingerprint_hash_core_test
	import wmfh_pkg::*;
();

	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          HOLD_OFF_CYCLES = 300;
	localparam int          SETTLE_CYCLES = 16;
	localparam int          PHASE_ITEMS = 256;
	localparam logic [7:0]  REG_UNUSED_LOW = 8'd2;
	localparam logic [7:0]  REG_UNUSED_HIGH = 8'hff;
	localparam logic [63:0] ALL_ONES = '1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;    // data_word [63:0], byte_count [66:64], zero fill
	logic [1:0]  s_tuser = '0;    // kind [1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;         // fingerprint [63:0], matches_expected [64], zero fill
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	int          fail_count;
	int          fp_pending;
	int          burst_left = 0;
	int          quiet_cycles = 0;
	logic        hold_req = 1'b0;
	int          hold_left = 0;
	int          stall_mode = 0;
	int          stall_mode_left = 0;
	logic [63:0] seen_fp = '0;

	word_mix_fingerprint_hash_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	word_mix_fingerprint_hash_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.fp_pending (fp_pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The receiver switches between stall patterns; a hold-off request overrides them all.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready = 1'b0;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_OFF_CYCLES - 1;
			m_tready = 1'b0;
		end else begin
			if (stall_mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_mode_left = $urandom_range(10, 60);
			end
			stall_mode_left--;
			case (stall_mode)
				0: m_tready = 1'b1;
				1: m_tready = ~m_tready;
				2: m_tready = 1'($urandom_range(0, 1));
				default: m_tready = ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			seen_fp <= m_tdata[63:0];
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("[word_mix_fingerprint_hash_core] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [2:0] random_count();
		return 3'($urandom_range(0, 7));
	endfunction

	task automatic offer(input kind_t kind, input logic [63:0] word, input logic [2:0] count);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = kind;
		s_tdata = {5'b0, count, word};
		do @(posedge clk); while (!s_tready);
	endtask

	// Drain every outstanding request, then give the core time to settle before a register write.
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (fp_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [7:0] index, input logic [63:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly well-formed runs (restart, words, integers, closing tail) with some loose items.
	task automatic random_phase(input int count, input bit with_hold_off);
		int sent;
		int words;
		sent = 0;
		while (sent < count) begin
			if (with_hold_off && sent >= count / 3) begin
				with_hold_off = 1'b0;
				hold_req = 1'b1;
			end
			if ($urandom_range(0, 9) < 8) begin
				offer(KIND_RESTART, random_word(), random_count());
				sent++;
				words = $urandom_range(0, 5);
				repeat (words) begin
					if ($urandom_range(0, 3) == 0) begin
						offer(KIND_INT, random_word(), random_count());
					end else begin
						offer(KIND_WORD, random_word(), random_count());
					end
					sent++;
				end
				offer(KIND_TAIL, random_word(), random_count());
				sent++;
			end else begin
				offer(kind_t'($urandom_range(0, 3)), random_word(), random_count());
				sent++;
			end
		end
	endtask

	initial begin
		logic [63:0] probe;
		logic [63:0] seed_pick;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset seed and accumulator, field extremes and ignored fields.
		offer(KIND_WORD, '0, 3'd7);
		offer(KIND_WORD, ALL_ONES, 3'd0);
		offer(KIND_INT, '0, 3'd5);
		offer(KIND_INT, ALL_ONES, 3'd7);
		for (int n = 0; n < 8; n++) begin
			offer(KIND_TAIL, ALL_ONES, 3'(n));
		end
		offer(KIND_TAIL, random_word(), 3'd3);
		offer(KIND_RESTART, ALL_ONES, 3'd7);
		offer(KIND_TAIL, random_word(), 3'd0);
		settle();

		// A zero seed with a zero target gives a match straight after restart.
		write_reg(REG_SEED, '0);
		write_reg(REG_EXPECTED, '0);
		probe = random_word();
		offer(KIND_RESTART, '0, 3'd0);
		offer(KIND_WORD, probe, 3'd2);
		settle();

		// Repeat the same run with its fingerprint as the target, so a mixed result matches.
		write_reg(REG_EXPECTED, seen_fp);
		write_reg(REG_UNUSED_LOW, ALL_ONES);
		write_reg(REG_UNUSED_HIGH, ALL_ONES);
		offer(KIND_RESTART, random_word(), 3'd4);
		offer(KIND_WORD, probe, 3'd6);
		settle();

		// A new seed does not disturb the accumulator until the next restart.
		write_reg(REG_SEED, ALL_ONES);
		write_reg(REG_EXPECTED, ALL_ONES);
		offer(KIND_INT, ALL_ONES, 3'd1);
		offer(KIND_RESTART, '0, 3'd0);
		offer(KIND_TAIL, ALL_ONES, 3'd7);
		settle();

		write_reg(REG_SEED, random_word());
		write_reg(REG_EXPECTED, random_word());
		random_phase(PHASE_ITEMS, 1'b1);
		settle();

		write_reg(REG_SEED, '0);
		write_reg(REG_EXPECTED, ALL_ONES);
		random_phase(PHASE_ITEMS, 1'b0);
		settle();

		write_reg(REG_SEED, ALL_ONES);
		write_reg(REG_EXPECTED, '0);
		random_phase(PHASE_ITEMS, 1'b0);
		settle();

		// Target equal to the seed, so every restart reports a match.
		seed_pick = random_word();
		write_reg(REG_SEED, seed_pick);
		write_reg(REG_EXPECTED, seed_pick);
		random_phase(PHASE_ITEMS, 1'b0);
		settle();

		if (fail_count == 0) begin
			$display("[word_mix_fingerprint_hash_core] OK");
		end else begin
			$display("[word_mix_fingerprint_hash_core] ERROR");
		end
		$finish;
	end

endmodule
